[design/tcs_pkg.sv]
// Shared types, constants and the CORDIC angle table of the truncated Cauchy sampler.
// No dependencies; the three cells and the top take names from here.
`default_nettype none
package tcs_pkg;

   localparam int CORDIC_STAGES_DEF = 24;
   localparam int VEC_W   = 60;
   localparam int ROT_W   = 33;
   localparam int ANG_W   = 32;
   localparam int QUOT_W  = 33;
   localparam int DVS_W   = 31;
   localparam int CSR_AW  = 4;
   localparam int DIV_CELLS = QUOT_W;

   localparam logic [1:0] REG_LOCATION    = 2'd0;
   localparam logic [1:0] REG_SCALE       = 2'd1;
   localparam logic [1:0] REG_LOWER_BOUND = 2'd2;
   localparam logic [1:0] REG_UPPER_BOUND = 2'd3;

   localparam logic [31:0] LOCATION_RST = 32'h0000_0000;
   localparam logic [30:0] SCALE_RST    = 31'h0001_0000;
   localparam logic [31:0] LOWER_RST    = 32'hFFFB_0000;
   localparam logic [31:0] UPPER_RST    = 32'h0005_0000;

   localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [ANG_W-1:0] NEG_QUARTER  = 32'hC000_0000;
   localparam logic [30:0]      MAG_MAX      = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [VEC_W-1:0] x_lo;
      logic [VEC_W-1:0] y_lo;
      logic [ANG_W-1:0] z_lo;
      logic [VEC_W-1:0] x_hi;
      logic [VEC_W-1:0] y_hi;
      logic [ANG_W-1:0] z_hi;
      logic [31:0]      u;
   } vec_type;

   typedef struct packed {
      logic [ROT_W-1:0] x;
      logic [ROT_W-1:0] y;
      logic [ANG_W-1:0] z;
   } rot_type;

   typedef struct packed {
      logic [DVS_W-1:0]  rem;
      logic [QUOT_W-1:0] bits;
      logic [DVS_W-1:0]  dvs;
      logic              nonpos;
      logic              neg;
      logic              ov;
   } div_type;

   function automatic logic [ANG_W-1:0] atan_entry(input int idx);
      logic [ANG_W-1:0] a;
      case (idx)
         0:  a = 32'd536870912;
         1:  a = 32'd316933406;
         2:  a = 32'd167458907;
         3:  a = 32'd85004756;
         4:  a = 32'd42667331;
         5:  a = 32'd21354465;
         6:  a = 32'd10679838;
         7:  a = 32'd5340245;
         8:  a = 32'd2670163;
         9:  a = 32'd1335087;
         10: a = 32'd667544;
         11: a = 32'd333772;
         12: a = 32'd166886;
         13: a = 32'd83443;
         14: a = 32'd41722;
         15: a = 32'd20861;
         16: a = 32'd10430;
         17: a = 32'd5215;
         18: a = 32'd2608;
         19: a = 32'd1304;
         20: a = 32'd652;
         21: a = 32'd326;
         22: a = 32'd163;
         23: a = 32'd81;
         24: a = 32'd41;
         25: a = 32'd20;
         26: a = 32'd10;
         27: a = 32'd5;
         28: a = 32'd3;
         29: a = 32'd1;
         30: a = 32'd1;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

[design/tcs_if.sv]
// Valid/ready channel interfaces for the sample requests and the results.
// Depends on nothing.
`default_nettype none
interface tcs_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] uniform_sample;
   modport source (output valid, output uniform_sample, input ready);
   modport sink   (input valid, input uniform_sample, output ready);
endinterface

interface tcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] sample_magnitude;
   logic [14:0] whole_part;
   logic        saturated;
   modport source (output valid, output sample_magnitude, output whole_part,
                   output saturated, input ready);
   modport sink   (input valid, input sample_magnitude, input whole_part,
                   input saturated, output ready);
endinterface
`default_nettype wire

[design/tcs_vec_cell.sv]
// One CORDIC vectoring step for both truncation bounds, registered.
// Depends on tcs_pkg.
`default_nettype none
module tcs_vec_cell #(
   parameter int STAGE = 0
) (
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire tcs_pkg::vec_type cell_in,
   output tcs_pkg::vec_type      cell_out
);

   localparam logic [tcs_pkg::ANG_W-1:0] ANG = tcs_pkg::atan_entry(STAGE);

   tcs_pkg::vec_type step_in;
   tcs_pkg::vec_type step_ff;

   always_comb begin
      logic signed [tcs_pkg::VEC_W-1:0] xl, yl, xh, yh;
      xl = $signed(cell_in.x_lo);
      yl = $signed(cell_in.y_lo);
      xh = $signed(cell_in.x_hi);
      yh = $signed(cell_in.y_hi);
      step_in = cell_in;
      if (yl > 0) begin
         step_in.x_lo = xl + (yl >>> STAGE);
         step_in.y_lo = yl - (xl >>> STAGE);
         step_in.z_lo = cell_in.z_lo + ANG;
      end else if (yl < 0) begin
         step_in.x_lo = xl - (yl >>> STAGE);
         step_in.y_lo = yl + (xl >>> STAGE);
         step_in.z_lo = cell_in.z_lo - ANG;
      end
      if (yh > 0) begin
         step_in.x_hi = xh + (yh >>> STAGE);
         step_in.y_hi = yh - (xh >>> STAGE);
         step_in.z_hi = cell_in.z_hi + ANG;
      end else if (yh < 0) begin
         step_in.x_hi = xh - (yh >>> STAGE);
         step_in.y_hi = yh + (xh >>> STAGE);
         step_in.z_hi = cell_in.z_hi - ANG;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         step_ff <= step_in;
      end
   end

   assign cell_out = step_ff;

endmodule
`default_nettype wire

[design/tcs_rot_cell.sv]
// One CORDIC rotation step toward the interpolated angle, registered.
// Depends on tcs_pkg.
`default_nettype none
module tcs_rot_cell #(
   parameter int STAGE = 0
) (
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire tcs_pkg::rot_type cell_in,
   output tcs_pkg::rot_type      cell_out
);

   localparam logic [tcs_pkg::ANG_W-1:0] ANG = tcs_pkg::atan_entry(STAGE);

   tcs_pkg::rot_type step_in;
   tcs_pkg::rot_type step_ff;

   always_comb begin
      logic signed [tcs_pkg::ROT_W-1:0] x, y;
      x = $signed(cell_in.x);
      y = $signed(cell_in.y);
      if (!cell_in.z[tcs_pkg::ANG_W-1]) begin
         step_in.x = x - (y >>> STAGE);
         step_in.y = y + (x >>> STAGE);
         step_in.z = cell_in.z - ANG;
      end else begin
         step_in.x = x + (y >>> STAGE);
         step_in.y = y - (x >>> STAGE);
         step_in.z = cell_in.z + ANG;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         step_ff <= step_in;
      end
   end

   assign cell_out = step_ff;

endmodule
`default_nettype wire

[design/tcs_div_cell.sv]
// One restoring division step: one quotient bit per cell, registered.
// Depends on tcs_pkg.
`default_nettype none
module tcs_div_cell (
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire tcs_pkg::div_type cell_in,
   output tcs_pkg::div_type      cell_out
);

   tcs_pkg::div_type step_in;
   tcs_pkg::div_type step_ff;

   always_comb begin
      logic [tcs_pkg::DVS_W:0] trial;
      logic [tcs_pkg::DVS_W:0] diff;
      trial = {cell_in.rem, cell_in.bits[tcs_pkg::QUOT_W-1]};
      diff  = trial - {1'b0, cell_in.dvs};
      step_in = cell_in;
      if (trial >= {1'b0, cell_in.dvs}) begin
         step_in.rem  = diff[tcs_pkg::DVS_W-1:0];
         step_in.bits = {cell_in.bits[tcs_pkg::QUOT_W-2:0], 1'b1};
      end else begin
         step_in.rem  = trial[tcs_pkg::DVS_W-1:0];
         step_in.bits = {cell_in.bits[tcs_pkg::QUOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         step_ff <= step_in;
      end
   end

   assign cell_out = step_ff;

endmodule
`default_nettype wire

[design/truncated_cauchy_sampler_top.sv]
// Truncated Cauchy sampler: one uniform Q0.32 word in, one |variate| in Q15.16 out.
// Takes one item per cycle while the chain is not halted; each item passes the two CORDIC
// chains and the 33-cell divider. The chain halts only when its last stage holds a result
// and the output register still waits. Depends on tcs_pkg, tcs_if and the three cells.
`default_nettype none
module truncated_cauchy_sampler_top #(
   parameter int CORDIC_STAGES = tcs_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   tcs_req_if.sink                        req,
   tcs_rsp_if.source                      rsp,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [tcs_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]               csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   localparam int CHAIN_LEN = 2 * CORDIC_STAGES + 4 + tcs_pkg::DIV_CELLS;

   logic [31:0] location_ff, lower_ff, upper_ff;
   logic [30:0] scale_ff;
   logic [CHAIN_LEN-1:0] valid_ff;
   logic advance;

   logic [1:0] csr_idx;
   assign csr_idx    = csr_paddr[tcs_pkg::CSR_AW-1:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         location_ff <= tcs_pkg::LOCATION_RST;
         scale_ff    <= tcs_pkg::SCALE_RST;
         lower_ff    <= tcs_pkg::LOWER_RST;
         upper_ff    <= tcs_pkg::UPPER_RST;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_idx)
            tcs_pkg::REG_LOCATION:    location_ff <= csr_pwdata;
            tcs_pkg::REG_SCALE:       scale_ff    <= csr_pwdata[30:0];
            tcs_pkg::REG_LOWER_BOUND: lower_ff    <= csr_pwdata;
            tcs_pkg::REG_UPPER_BOUND: upper_ff    <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         tcs_pkg::REG_LOCATION:    csr_prdata = location_ff;
         tcs_pkg::REG_SCALE:       csr_prdata = {1'b0, scale_ff};
         tcs_pkg::REG_LOWER_BOUND: csr_prdata = lower_ff;
         tcs_pkg::REG_UPPER_BOUND: csr_prdata = upper_ff;
         default:                  csr_prdata = 32'd0;
      endcase
   end

   // vectoring chain
   tcs_pkg::vec_type vec_q [CORDIC_STAGES+1];

   always_comb begin
      logic [32:0] dy_lo, dy_hi;
      dy_lo = {lower_ff[31], lower_ff} - {location_ff[31], location_ff};
      dy_hi = {upper_ff[31], upper_ff} - {location_ff[31], location_ff};
      vec_q[0].x_lo = {5'd0, scale_ff, 24'd0};
      vec_q[0].y_lo = {{3{dy_lo[32]}}, dy_lo, 24'd0};
      vec_q[0].z_lo = '0;
      vec_q[0].x_hi = {5'd0, scale_ff, 24'd0};
      vec_q[0].y_hi = {{3{dy_hi[32]}}, dy_hi, 24'd0};
      vec_q[0].z_hi = '0;
      vec_q[0].u    = req.uniform_sample;
   end

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
      tcs_vec_cell #(.STAGE(g)) u_cell (
         .clock(clock), .enable(advance), .cell_in(vec_q[g]), .cell_out(vec_q[g+1])
      );
   end

   // interpolation between the bound angles
   logic signed [49:0] ph_ff, pl_ff;
   logic [31:0] alo_ff;
   logic [31:0] theta_ff;

   always_ff @(posedge clock) begin
      logic [31:0] a_lo, a_hi;
      logic signed [32:0] d;
      a_lo = vec_q[CORDIC_STAGES].z_lo;
      a_hi = vec_q[CORDIC_STAGES].z_hi;
      if ($signed(a_lo) > $signed(tcs_pkg::QUARTER_TURN)) a_lo = tcs_pkg::QUARTER_TURN;
      if ($signed(a_lo) < $signed(tcs_pkg::NEG_QUARTER))  a_lo = tcs_pkg::NEG_QUARTER;
      if ($signed(a_hi) > $signed(tcs_pkg::QUARTER_TURN)) a_hi = tcs_pkg::QUARTER_TURN;
      if ($signed(a_hi) < $signed(tcs_pkg::NEG_QUARTER))  a_hi = tcs_pkg::NEG_QUARTER;
      d = $signed({a_hi[31], a_hi}) - $signed({a_lo[31], a_lo});
      if (advance) begin
         ph_ff  <= d * $signed({1'b0, vec_q[CORDIC_STAGES].u[31:16]});
         pl_ff  <= d * $signed({1'b0, vec_q[CORDIC_STAGES].u[15:0]});
         alo_ff <= a_lo;
      end
   end

   always_ff @(posedge clock) begin
      logic [65:0] sum;
      logic [33:0] th;
      sum = {ph_ff, 16'd0} + {{16{pl_ff[49]}}, pl_ff};
      th  = {{2{alo_ff[31]}}, alo_ff} + sum[65:32];
      if (advance) begin
         theta_ff <= th[31:0];
      end
   end

   // rotation chain
   tcs_pkg::rot_type rot_q [CORDIC_STAGES+1];

   assign rot_q[0].x = 33'h0_4000_0000;
   assign rot_q[0].y = '0;
   assign rot_q[0].z = theta_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
      tcs_rot_cell #(.STAGE(g)) u_cell (
         .clock(clock), .enable(advance), .cell_in(rot_q[g]), .cell_out(rot_q[g+1])
      );
   end

   // scale * |sin| and divider setup
   logic [62:0] num_ff;
   logic [tcs_pkg::DVS_W-1:0] dvs_ff;
   logic nonpos_ff, neg_ff;

   always_ff @(posedge clock) begin
      logic [32:0] rx, ry, ay;
      rx = rot_q[CORDIC_STAGES].x;
      ry = rot_q[CORDIC_STAGES].y;
      ay = ry[32] ? -ry : ry;
      if (advance) begin
         num_ff    <= 63'(scale_ff) * 63'(ay[31:0]);
         dvs_ff    <= rx[tcs_pkg::DVS_W-1:0];
         nonpos_ff <= rx[32] || (rx == 33'd0);
         neg_ff    <= ry[32];
      end
   end

   tcs_pkg::div_type div_q [tcs_pkg::DIV_CELLS+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         div_q[0].rem    <= {1'b0, num_ff[62:33]};
         div_q[0].bits   <= num_ff[32:0];
         div_q[0].dvs    <= dvs_ff;
         div_q[0].nonpos <= nonpos_ff;
         div_q[0].neg    <= neg_ff;
         div_q[0].ov     <= {1'b0, num_ff[62:33]} >= dvs_ff;
      end
   end

   for (genvar g = 0; g < tcs_pkg::DIV_CELLS; g++) begin : g_div
      tcs_div_cell u_cell (
         .clock(clock), .enable(advance), .cell_in(div_q[g]), .cell_out(div_q[g+1])
      );
   end

   // output register
   logic        rsp_valid_ff;
   logic [30:0] rsp_mag_ff;
   logic [14:0] rsp_whole_ff;
   logic        rsp_sat_ff;
   logic [30:0] mag_in;
   logic        sat_in;

   always_comb begin
      logic [34:0] qv, r, mag;
      logic [tcs_pkg::QUOT_W-1:0] quo;
      quo = div_q[tcs_pkg::DIV_CELLS].bits;
      qv  = div_q[tcs_pkg::DIV_CELLS].neg ? -{2'b00, quo} : {2'b00, quo};
      r   = {{3{location_ff[31]}}, location_ff} + qv;
      mag = r[34] ? -r : r;
      sat_in = div_q[tcs_pkg::DIV_CELLS].nonpos || div_q[tcs_pkg::DIV_CELLS].ov ||
               (mag > {4'd0, tcs_pkg::MAG_MAX});
      mag_in = sat_in ? tcs_pkg::MAG_MAX : mag[30:0];
   end

   assign advance = !(valid_ff[CHAIN_LEN-1] && rsp_valid_ff && !rsp.ready);
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            valid_ff <= {valid_ff[CHAIN_LEN-2:0], req.valid};
         end
         if (advance && valid_ff[CHAIN_LEN-1]) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && valid_ff[CHAIN_LEN-1]) begin
         rsp_mag_ff   <= mag_in;
         rsp_whole_ff <= mag_in[30:16];
         rsp_sat_ff   <= sat_in;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.sample_magnitude = rsp_mag_ff;
   assign rsp.whole_part       = rsp_whole_ff;
   assign rsp.saturated        = rsp_sat_ff;

   a_sat_clamps: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.saturated |-> rsp.sample_magnitude == tcs_pkg::MAG_MAX)
      else $error("saturated result not clamped");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> valid_ff[0])
      else $error("accepted transfer missing from first stage");

   a_tail_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff[CHAIN_LEN-1] && !advance |=> valid_ff[CHAIN_LEN-1])
      else $error("stalled chain tail dropped");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && !valid_ff[CHAIN_LEN-1] |=> !rsp.valid)
      else $error("output repeated after transfer");

endmodule
`default_nettype wire
